### hdl/upd_pkg.sv
`default_nettype none
package upd_pkg;

  localparam int unsigned RunMax = 3;

  localparam logic [7:0] ChPlus    = 8'h2B;
  localparam logic [7:0] ChPercent = 8'h25;
  localparam logic [7:0] ChSpace   = 8'h20;

  typedef struct packed {
    logic [RunMax-1:0][7:0] bytes;
    logic [1:0]             cnt;
    logic                   last;
  } run_t;

endpackage
`default_nettype wire

### hdl/upd_front.sv
`default_nettype none
module upd_front (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_byte,
  input  wire logic        in_last,
  input  wire logic        q_full,
  output logic             push,
  output upd_pkg::run_t    push_run
);
  import upd_pkg::*;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_PCT,
    PH_DIGIT
  } phase_t;

  phase_t     phase, phase_next;
  logic [7:0] held, held_next;
  run_t       run;
  logic       accept;

  function automatic logic is_hex(logic [7:0] c);
    logic [7:0] lc;
    lc = c | 8'h20;
    is_hex = (c >= 8'h30 && c <= 8'h39) || (lc >= 8'h61 && lc <= 8'h66);
  endfunction

  function automatic logic [3:0] hex_val(logic [7:0] c);
    if (c <= 8'h39) begin
      hex_val = c[3:0];
    end else begin
      hex_val = c[3:0] + 4'd9;
    end
  endfunction

  function automatic run_t append(run_t r, logic [7:0] b);
    run_t o;
    o = r;
    if (r.cnt != 2'd3) begin
      o.bytes[r.cnt] = b;
      o.cnt = r.cnt + 2'd1;
    end
    append = o;
  endfunction

  always_comb begin
    logic plain_needed;
    run = '0;
    run.last = in_last;
    phase_next = phase;
    held_next = held;
    plain_needed = 1'b0;
    case (phase)
      PH_PCT: begin
        if (is_hex(in_byte)) begin
          held_next = in_byte;
          phase_next = PH_DIGIT;
        end else begin
          phase_next = PH_IDLE;
          run = append(run, ChPercent);
          plain_needed = 1'b1;
        end
      end
      PH_DIGIT: begin
        phase_next = PH_IDLE;
        if (is_hex(in_byte)) begin
          run = append(run, {hex_val(held), hex_val(in_byte)});
        end else begin
          run = append(run, ChPercent);
          run = append(run, held);
          plain_needed = 1'b1;
        end
      end
      default: begin
        phase_next = PH_IDLE;
        plain_needed = 1'b1;
      end
    endcase
    if (plain_needed) begin
      if (in_byte == ChPlus) begin
        run = append(run, ChSpace);
      end else if (in_byte == ChPercent) begin
        phase_next = PH_PCT;
      end else begin
        run = append(run, in_byte);
      end
    end
    if (in_last) begin
      if (phase_next == PH_PCT) begin
        run = append(run, ChPercent);
      end else if (phase_next == PH_DIGIT) begin
        run = append(run, ChPercent);
        run = append(run, held_next);
      end
      phase_next = PH_IDLE;
      held_next = '0;
    end
  end

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;
  assign push     = accept && (run.cnt != 2'd0);
  assign push_run = run;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
      held  <= '0;
    end else if (accept) begin
      phase <= phase_next;
      held  <= held_next;
    end
  end

endmodule
`default_nettype wire

### hdl/upd_queue.sv
`default_nettype none
module upd_queue (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  wire upd_pkg::run_t push_run,
  output logic               full,
  input  wire logic          pop,
  output logic               nonempty,
  output upd_pkg::run_t      head
);
  import upd_pkg::*;

  run_t       mem [2];
  logic       wptr, rptr;
  logic [1:0] count;

  assign full     = (count == 2'd2);
  assign nonempty = (count != 2'd0);
  assign head     = mem[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= push_run;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) begin
        wptr <= ~wptr;
      end
      if (pop) begin
        rptr <= ~rptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule
`default_nettype wire

### hdl/upd_back.sv
`default_nettype none
module upd_back (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          nonempty,
  input  wire upd_pkg::run_t head,
  output logic               pop,
  output logic               out_valid,
  input  wire logic          out_stall,
  output logic [7:0]         out_byte,
  output logic               run_last,
  output logic               msg_last
);
  import upd_pkg::*;

  logic [1:0] idx;
  logic       xfer;

  assign out_valid = nonempty;
  assign out_byte  = head.bytes[idx];
  assign run_last  = (idx == head.cnt - 2'd1);
  assign msg_last  = run_last && head.last;
  assign xfer      = nonempty && !out_stall;
  assign pop       = xfer && run_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= 2'd0;
    end else if (pop) begin
      idx <= 2'd0;
    end else if (xfer) begin
      idx <= idx + 2'd1;
    end
  end

endmodule
`default_nettype wire

### hdl/url_percent_decoder_top.sv
`default_nettype none
// Channel | Handshake           | Payload
// input   | in_valid, in_stall  | in_byte, in_last
// output  | out_valid, out_stall| out_byte, run_last, msg_last
// Each input byte is classified in the cycle it transfers; its zero to three
// results go into a two-entry queue and leave one byte per cycle unless
// out_stall is high. Sustained rate is one input per cycle while each input
// yields at most one byte and out_stall is low; a longer run holds its entry
// until its last byte leaves. in_stall rises only when the queue is full.
// Synchronous reset clears the escape state and empties the queue.
module url_percent_decoder_top (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_byte,
  input  wire logic       in_last,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      out_byte,
  output logic            run_last,
  output logic            msg_last
);
  import upd_pkg::*;

  logic push, pop, q_full, q_nonempty;
  run_t push_run, head;

  upd_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_byte  (in_byte),
    .in_last  (in_last),
    .q_full   (q_full),
    .push     (push),
    .push_run (push_run)
  );

  upd_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_run (push_run),
    .full     (q_full),
    .pop      (pop),
    .nonempty (q_nonempty),
    .head     (head)
  );

  upd_back u_back (
    .clk       (clk),
    .rst       (rst),
    .nonempty  (q_nonempty),
    .head      (head),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_byte  (out_byte),
    .run_last  (run_last),
    .msg_last  (msg_last)
  );

endmodule
`default_nettype wire
